>>> rtl/fgc_pkg.sv
`timescale 1ns / 1ps

package fgc_pkg;

	// Storage sizes.
	localparam int MAX_TAPS    = 1024;
	localparam int MODEL_COUNT = 4;
	localparam int COEF_DEPTH  = MODEL_COUNT * MAX_TAPS;

	// Derived widths.
	localparam int TAP_W   = $clog2(MAX_TAPS);
	localparam int CNT_W   = $clog2(MAX_TAPS + 1);
	localparam int COEF_AW = $clog2(COEF_DEPTH);

	// Fixed field widths.
	localparam int SAMPLE_W  = 16;
	localparam int MODEL_W   = 2;
	localparam int INDEX_W   = 10;
	localparam int TAPCNT_W  = 11;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = 2 * SAMPLE_W;
	localparam int ACC_W     = PROD_W + TAP_W + 1;

	// Reset values of the configuration registers.
	localparam logic signed [SAMPLE_W-1:0] GAIN_RESET    = 16'sd4096;
	localparam logic [TAPCNT_W-1:0]        TAPCNT_RESET  = 11'd1024;

	// Operation codes of an input item.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACTIVE_MODEL = 2'd0,
		REG_GAIN         = 2'd1,
		REG_TAP_COUNT    = 2'd2
	} fgc_cfg_reg_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_STORE,
		ST_ISSUE,
		ST_DRAIN,
		ST_FINISH
	} fgc_state_t;

	// Input item.
	typedef struct packed {
		logic                       op;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [MODEL_W-1:0]         coef_model;
		logic [INDEX_W-1:0]         coef_index;
		logic signed [SAMPLE_W-1:0] coef_value;
		logic                       block_end;
	} fgc_in_t;

	// Result item.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       block_end_out;
	} fgc_out_t;

	// Control from the sequencer to the history ring.
	typedef struct packed {
		logic                       wr_en;
		logic signed [SAMPLE_W-1:0] wr_data;
		logic                       rd_en;
		logic [TAP_W-1:0]           rd_lag;
	} fgc_hist_req_t;

	// Round a Q4.12 by Q1.15 product back to Q1.15 and saturate.
	function automatic logic signed [SAMPLE_W-1:0] scale_sat(
		input logic signed [PROD_W-1:0] p
	);
		logic signed [PROD_W:0] t;
		t = {p[PROD_W-1], p} + (PROD_W + 1)'(2048);
		t = t >>> 12;
		if (t > $signed((PROD_W + 1)'(32767))) begin
			return 16'sh7FFF;
		end else if (t < -$signed((PROD_W + 1)'(32768))) begin
			return 16'sh8000;
		end
		return t[SAMPLE_W-1:0];
	endfunction

	// Round a Q13.30 sum to Q1.15 and saturate.
	function automatic logic signed [SAMPLE_W-1:0] out_sat(
		input logic signed [ACC_W-1:0] a
	);
		logic signed [ACC_W:0] t;
		t = {a[ACC_W-1], a} + (ACC_W + 1)'(16384);
		t = t >>> 15;
		if (t > $signed((ACC_W + 1)'(32767))) begin
			return 16'sh7FFF;
		end else if (t < -$signed((ACC_W + 1)'(32768))) begin
			return 16'sh8000;
		end
		return t[SAMPLE_W-1:0];
	endfunction

endpackage

>>> rtl/fgc_hist.sv
`timescale 1ns / 1ps

module fgc_hist (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fgc_pkg::fgc_hist_req_t             req,
	output logic signed [fgc_pkg::SAMPLE_W-1:0] rd_data
);
	import fgc_pkg::*;

	logic signed [SAMPLE_W-1:0] mem [MAX_TAPS];
	logic [TAP_W-1:0]           wp_q;
	logic [TAP_W-1:0]           last_q;
	logic [CNT_W-1:0]           fill_q;
	logic [TAP_W-1:0]           rd_addr;
	logic signed [SAMPLE_W-1:0] rd_q;
	logic                       zero_s1;

	// Position of the sample that lies rd_lag items before the newest one.
	always_comb begin
		if (last_q >= req.rd_lag) begin
			rd_addr = last_q - req.rd_lag;
		end else begin
			rd_addr = last_q + TAP_W'(MAX_TAPS) - req.rd_lag;
		end
	end

	// Write pointer and fill count; entries never written read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			last_q <= '0;
			fill_q <= '0;
		end else if (req.wr_en) begin
			last_q <= wp_q;
			if (wp_q == TAP_W'(MAX_TAPS - 1)) begin
				wp_q <= '0;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
			if (fill_q != CNT_W'(MAX_TAPS)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Ring storage with a registered read port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wp_q] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q    <= mem[rd_addr];
			zero_s1 <= (CNT_W'(req.rd_lag) >= fill_q);
		end
	end

	assign rd_data = zero_s1 ? '0 : rd_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_TAPS))
		else $error("history fill count beyond ring depth");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.wr_en && req.rd_en))
		else $error("history written and read in the same cycle");

endmodule

>>> rtl/fgc_coef.sv
`timescale 1ns / 1ps

module fgc_coef (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [fgc_pkg::COEF_AW-1:0]         wr_addr,
	input  logic signed [fgc_pkg::SAMPLE_W-1:0] wr_data,
	input  logic                                rd_en,
	input  logic [fgc_pkg::COEF_AW-1:0]         rd_addr,
	output logic signed [fgc_pkg::SAMPLE_W-1:0] rd_data
);
	import fgc_pkg::*;

	logic signed [SAMPLE_W-1:0] mem [COEF_DEPTH];

	// Coefficient store of all models, one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/fgc_mac.sv
`timescale 1ns / 1ps

module fgc_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clear,
	input  logic                                data_valid,
	input  logic signed [fgc_pkg::SAMPLE_W-1:0] hist,
	input  logic signed [fgc_pkg::SAMPLE_W-1:0] coef,
	output logic signed [fgc_pkg::ACC_W-1:0]    acc,
	output logic                                busy
);
	import fgc_pkg::*;

	logic signed [PROD_W-1:0] prod_s2;
	logic                     valid_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// Product stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= hist * coef;
	end

	// Accumulate stage.
	always_ff @(posedge clk) begin
		if (clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign acc  = acc_q;
	assign busy = valid_s2;

endmodule

>>> rtl/fir_filter_gain_clamp.sv
`timescale 1ns / 1ps

// Direct-form FIR filter with input gain and output clamp. A coefficient item
// writes one tap of one of four models as it is accepted and gives no result.
// A sample item is scaled by the Q4.12 gain, stored in a 1024-entry history
// ring, and convolved with the active model over N = min(tap_count, 1024) taps
// by one multiply-accumulate unit that reads one history entry and one
// coefficient per cycle; the item steps through scale, store, issue and drain
// (when N is nonzero) and finish to a result in the output register. The next
// item is accepted once the result is in the output register, even if it has
// not been taken yet. History entries not yet written since reset read as zero
// through a fill count, so there is no clearing pass after reset. Taps that
// were never written must not be used. Configuration writes are accepted at
// any time and should be made while no sample is in flight.
module fir_filter_gain_clamp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  fgc_pkg::fgc_in_t                  req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output fgc_pkg::fgc_out_t                 rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fgc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fgc_pkg::SAMPLE_W-1:0]      cfg_data
);
	import fgc_pkg::*;

	fgc_state_t                 state_q, state_d;
	logic [MODEL_W-1:0]         active_model_q;
	logic signed [SAMPLE_W-1:0] gain_q;
	logic [TAPCNT_W-1:0]        tap_count_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       be_q;
	logic signed [PROD_W-1:0]   scaled_q;
	logic [CNT_W-1:0]           k_q;
	logic [CNT_W-1:0]           taps_eff;
	logic                       model_ok;
	logic                       rd_valid_s1;
	logic                       rsp_valid_q;
	fgc_out_t                   rsp_q;
	logic                       req_acc;
	logic                       coef_wr_en;
	logic [COEF_AW-1:0]         coef_wr_addr;
	logic [COEF_AW-1:0]         coef_rd_addr;
	logic signed [SAMPLE_W-1:0] coef_rd_data;
	logic signed [SAMPLE_W-1:0] hist_rd_data;
	fgc_hist_req_t              hist_req;
	logic                       rd_en;
	logic                       mac_clear;
	logic                       load_rsp;
	logic signed [ACC_W-1:0]    acc;
	logic                       mac_busy;

	assign cfg_ready = 1'b1;
	assign req_acc   = req_valid && req_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_model_q <= '0;
			gain_q         <= GAIN_RESET;
			tap_count_q    <= TAPCNT_RESET;
		end else if (cfg_valid) begin
			case (fgc_cfg_reg_t'(cfg_index))
				REG_ACTIVE_MODEL: active_model_q <= cfg_data[MODEL_W-1:0];
				REG_GAIN:         gain_q         <= cfg_data;
				REG_TAP_COUNT:    tap_count_q    <= cfg_data[TAPCNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective tap count and model range check.
	assign taps_eff = (int'(tap_count_q) > MAX_TAPS) ? CNT_W'(MAX_TAPS)
		: CNT_W'(tap_count_q);
	assign model_ok = int'(active_model_q) < MODEL_COUNT;

	// Coefficient writes go straight to the store when the item is accepted.
	assign coef_wr_en = req_acc && (req.op == OP_COEF)
		&& (int'(req.coef_model) < MODEL_COUNT) && (int'(req.coef_index) < MAX_TAPS);
	assign coef_wr_addr = COEF_AW'(int'(req.coef_model) * MAX_TAPS + int'(req.coef_index));
	assign coef_rd_addr = COEF_AW'(int'(active_model_q) * MAX_TAPS + int'(k_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && req.op == OP_SAMPLE) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_STORE;
			ST_STORE: begin
				if (taps_eff == '0 || !model_ok) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (k_q + 1'b1 == taps_eff) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_valid_s1 && !mac_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req_ready = 1'b0;
		mac_clear = 1'b0;
		rd_en     = 1'b0;
		load_rsp  = 1'b0;
		hist_req  = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				mac_clear = 1'b1;
			end
			ST_STORE: begin
				hist_req.wr_en   = 1'b1;
				hist_req.wr_data = scale_sat(scaled_q);
			end
			ST_ISSUE: begin
				rd_en           = 1'b1;
				hist_req.rd_en  = 1'b1;
				hist_req.rd_lag = k_q[TAP_W-1:0];
			end
			ST_FINISH: load_rsp = !rsp_valid_q || rsp_ready;
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			k_q         <= '0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == ST_STORE) begin
				k_q <= '0;
			end else if (rd_en) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	// Sample path: capture, gain product, result.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			x_q  <= req.sample_in;
			be_q <= req.block_end;
		end
		if (state_q == ST_SCALE) begin
			scaled_q <= x_q * gain_q;
		end
		if (load_rsp) begin
			rsp_q.sample_out    <= out_sat(acc);
			rsp_q.block_end_out <= be_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	fgc_hist u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (hist_req),
		.rd_data (hist_rd_data)
	);

	fgc_coef u_coef (
		.clk     (clk),
		.wr_en   (coef_wr_en),
		.wr_addr (coef_wr_addr),
		.wr_data (req.coef_value),
		.rd_en   (rd_en),
		.rd_addr (coef_rd_addr),
		.rd_data (coef_rd_data)
	);

	fgc_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (mac_clear),
		.data_valid (rd_valid_s1),
		.hist       (hist_rd_data),
		.coef       (coef_rd_data),
		.acc        (acc),
		.busy       (mac_busy)
	);

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (!rd_valid_s1 && !mac_busy))
		else $error("result taken while products still in flight");

	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (k_q < taps_eff))
		else $error("tap counter ran past the tap count");

	a_coef_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.op == OP_COEF) |=> (state_q == ST_IDLE))
		else $error("coefficient item left the idle state");

endmodule
